// ----- rtl/srp_pkg.sv -----
// Shared types and constants for the reference-counted surface pool.
// Used by srp_cell and refcounted_surface_pool; depends on nothing else.
package srp_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = SLOT_W + 1;
    localparam int ID_W      = 32;
    localparam int CNT_W     = 8;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 48;
    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(MAX_SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_REF   = 2'd2,
        CMD_UNREF = 2'd3
    } srp_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOFREE   = 2'd1,
        STATUS_NOTFOUND = 2'd2
    } srp_status_t;

    typedef enum logic [1:0] {
        UPD_NONE = 2'd0,
        UPD_LOAD = 2'd1,
        UPD_INC  = 2'd2,
        UPD_DEC  = 2'd3
    } srp_upd_op_t;

    // Search control broadcast to every cell
    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] start_slot;
        logic              run;
        logic              mode_ref;
        logic [ID_W-1:0]   key;
    } srp_ctl_t;

    // Slot update broadcast to every cell
    typedef struct packed {
        srp_upd_op_t       op;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
    } srp_upd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } srp_state_t;

endpackage

// ----- rtl/srp_cell.sv -----
// One slot of the surface pool: identifier, reference count and search token.
// Depends on srp_pkg.
module srp_cell
    import srp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] cell_idx,
    input  srp_ctl_t          ctl,
    input  srp_upd_t          upd,
    input  logic              tok_in,
    output logic              tok_out,
    output logic              hit,
    output logic [ID_W-1:0]   id_out,
    output logic [CNT_W-1:0]  count_out
);

    logic [ID_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             tok_reg, tok_next;
    logic             sel;

    assign sel = (upd.slot == cell_idx);

    always_comb begin
        id_next    = id_reg;
        count_next = count_reg;
        if (sel) begin
            unique case (upd.op)
                UPD_LOAD: begin
                    id_next    = upd.id;
                    count_next = '0;
                end
                UPD_INC: begin
                    if (count_reg != '1) count_next = count_reg + CNT_W'(1);
                end
                UPD_DEC: begin
                    if (count_reg != '0) count_next = count_reg - CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Take the token at search start, then pass it along the row
    always_comb begin
        if (ctl.start) begin
            tok_next = (ctl.start_slot == cell_idx);
        end else if (ctl.run) begin
            tok_next = tok_in;
        end else begin
            tok_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg    <= '0;
            count_reg <= '0;
            tok_reg   <= 1'b0;
        end else begin
            id_reg    <= id_next;
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out   = tok_reg;
    assign hit       = tok_reg & (ctl.mode_ref ? (id_reg == ctl.key) : (count_reg == '0));
    assign id_out    = id_reg;
    assign count_out = count_reg;

endmodule

// ----- rtl/refcounted_surface_pool.sv -----
// Top level of the reference-counted surface pool: control sequencer,
// output register and the row of srp_cell slots. Depends on srp_pkg, srp_cell.
//
// Usage:
//   Commands enter on the s_ stream channel, one result per command leaves
//   on the m_ stream channel. cfg_valid/cfg_data write pool_size (always ready).
//   Load and unref act on the addressed slot directly: the done state writes
//   the result into the output register once it is free, and the next item
//   is accepted only after the sequencer returns to idle.
//   Allocate and ref pass a search token along the row of slot cells, one
//   slot per cycle, wrapping at the effective pool size. A search visits up
//   to n slots (n = effective pool size, at most 32) before the done state
//   writes the result, and the next item is taken once the sequencer is idle.
//   One command is in flight at a time; s_tready is high whenever the
//   sequencer is idle, even while a finished result still waits on m_.
//   If the receiver stalls, the finished result holds in the sequencer
//   until the output register frees up; the payload holds stable.
//   Reset (aresetn low, synchronous) clears every identifier and count,
//   the current allocation slot, and sets pool_size to 32.
module refcounted_surface_pool
    import srp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration write: pool_size
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SIZE_W-1:0]   cfg_data,
    // Commands: [1:0] command, [6:2] slot, [38:7] surface_id, [39] zero
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // Results: [1:0] status, [6:2] result_slot, [38:7] result_id, [46:39] ref_count,
    // [47] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    // Command fields
    srp_cmd_t          in_cmd;
    logic [SLOT_W-1:0] in_slot;
    logic [ID_W-1:0]   in_id;

    assign in_cmd  = srp_cmd_t'(s_tdata[1:0]);
    assign in_slot = s_tdata[2 +: SLOT_W];
    assign in_id   = s_tdata[7 +: ID_W];

    // Sequencer state
    srp_state_t        state_reg, state_next;
    logic [SIZE_W-1:0] pool_size_reg, pool_size_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SIZE_W-1:0] steps_reg, steps_next;
    logic              mode_ref_reg, mode_ref_next;
    logic [ID_W-1:0]   key_reg, key_next;
    srp_status_t       res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // Cell row
    srp_ctl_t          ctl;
    srp_upd_t          upd;
    logic [MAX_SLOTS-1:0] tok_vec, tok_in_vec, hit_vec, last_mask;
    logic [ID_W-1:0]   cell_id  [MAX_SLOTS];
    logic [CNT_W-1:0]  cell_cnt [MAX_SLOTS];

    logic [SIZE_W-1:0] n_eff, n_last, cur_inc;
    logic [SLOT_W-1:0] alloc_start, pos_wrap;
    logic              accept, found, stop_cur, last_step, out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign out_free  = ~m_valid_reg | m_tready;

    // Effective pool size: zero acts as one, clip at the row length
    always_comb begin
        if (pool_size_reg == '0) begin
            n_eff = SIZE_W'(1);
        end else if (pool_size_reg > SIZE_W'(MAX_SLOTS)) begin
            n_eff = SIZE_W'(MAX_SLOTS);
        end else begin
            n_eff = pool_size_reg;
        end
    end

    assign n_last      = n_eff - SIZE_W'(1);
    assign cur_inc     = {1'b0, cur_reg} + SIZE_W'(1);
    assign alloc_start = (cur_inc >= n_eff) ? '0 : cur_inc[SLOT_W-1:0];
    assign pos_wrap    = ({1'b0, pos_reg} == n_last) ? '0 : pos_reg + SLOT_W'(1);

    // Token ring: the last slot in use hands back to slot zero
    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_row
            assign last_mask[gi] = (n_last == SIZE_W'(gi));
            if (gi == 0) begin : g_head
                assign tok_in_vec[gi] = |(tok_vec & last_mask);
            end else begin : g_link
                assign tok_in_vec[gi] = tok_vec[gi-1] & ~last_mask[gi-1];
            end
            srp_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cell_idx  (SLOT_W'(gi)),
                .ctl       (ctl),
                .upd       (upd),
                .tok_in    (tok_in_vec[gi]),
                .tok_out   (tok_vec[gi]),
                .hit       (hit_vec[gi]),
                .id_out    (cell_id[gi]),
                .count_out (cell_cnt[gi])
            );
        end
    endgenerate

    // A candidate at the current slot ends an allocate lap without a match
    assign stop_cur  = ~mode_ref_reg & (pos_reg == cur_reg);
    assign found     = (|hit_vec) & ~stop_cur;
    assign last_step = (steps_reg == n_last);

    always_comb begin
        state_next      = state_reg;
        pool_size_next  = pool_size_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        steps_next      = steps_reg;
        mode_ref_next   = mode_ref_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        ctl.start       = 1'b0;
        ctl.start_slot  = '0;
        ctl.run         = (state_reg == ST_SCAN);
        ctl.mode_ref    = mode_ref_reg;
        ctl.key         = key_reg;
        upd.op          = UPD_NONE;
        upd.slot        = in_slot;
        upd.id          = in_id;

        if (cfg_valid) pool_size_next = cfg_data;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_status_next = STATUS_OK;
                    res_slot_next   = in_slot;
                    key_next        = in_id;
                    steps_next      = '0;
                    unique case (in_cmd)
                        CMD_LOAD: begin
                            upd.op     = UPD_LOAD;
                            state_next = ST_DONE;
                        end
                        CMD_UNREF: begin
                            upd.op     = UPD_DEC;
                            state_next = ST_DONE;
                        end
                        CMD_ALLOC: begin
                            ctl.start      = 1'b1;
                            ctl.start_slot = alloc_start;
                            pos_next       = alloc_start;
                            mode_ref_next  = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        CMD_REF: begin
                            ctl.start      = 1'b1;
                            ctl.start_slot = '0;
                            pos_next       = '0;
                            mode_ref_next  = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // Advance the token one slot per cycle until a hit or a full lap
                priority if (found) begin
                    res_status_next = STATUS_OK;
                    res_slot_next   = pos_reg;
                    if (mode_ref_reg) begin
                        upd.op   = UPD_INC;
                        upd.slot = pos_reg;
                    end else begin
                        cur_next = pos_reg;
                    end
                    state_next = ST_DONE;
                end else if (stop_cur || last_step) begin
                    res_status_next = mode_ref_reg ? STATUS_NOTFOUND : STATUS_NOFREE;
                    res_slot_next   = '0;
                    state_next      = ST_DONE;
                end else begin
                    pos_next   = pos_wrap;
                    steps_next = steps_reg + SIZE_W'(1);
                end
            end
            ST_DONE: begin
                // Hold the result here until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (res_status_reg == STATUS_OK) begin
                        m_data_next = {1'b0, cell_cnt[res_slot_reg], cell_id[res_slot_reg],
                                       res_slot_reg, res_status_reg};
                    end else begin
                        m_data_next = {1'b0, CNT_W'(0), ID_W'(0), SLOT_W'(0), res_status_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pool_size_reg <= POOL_RESET;
            cur_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pool_size_reg <= pool_size_next;
            cur_reg       <= cur_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        steps_reg      <= steps_next;
        mode_ref_reg   <= mode_ref_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
